// ===== src/fpsh_pkg.sv =====
// Shared types, constants and tables for the fix pair speed and heading block.
`timescale 1ns / 1ps

package fpsh_pkg;

    // Field widths
    localparam int TRACK_SLOTS_DEF = 32;
    localparam int SLOT_IN_W       = 5;
    localparam int POS_W           = 24;
    localparam int DIFF_W          = 25;
    localparam int TIME_W          = 32;
    localparam int VAL_W           = 16;
    localparam int CFG_IDX_W       = 2;

    // Datapath widths
    localparam int MUL_W        = 30;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int D2_W         = 50;
    localparam int RAD_W        = 58;
    localparam int ROOT_W       = 29;
    localparam int REM_W        = 33;
    localparam int SCALED_W     = 39;
    localparam int DIV_STEPS    = 16;
    localparam int SQRT_STEPS   = 29;
    localparam int STEP_W       = 5;
    localparam int CORDIC_STEPS = 20;
    localparam int CX_W         = 44;
    localparam int Z_W          = 34;
    localparam int ATAN_W       = 29;
    localparam int ANG_FRAC     = 16;

    localparam logic [VAL_W-1:0] SPEED_SCALE = 16'd1000;
    localparam logic [VAL_W-1:0] SPEED_MAX   = 16'hFFFF;
    localparam logic [VAL_W-1:0] COURSE_WRAP = 16'd36000;

    // Angles in 1/65536 of 0.01 degree
    localparam logic signed [Z_W-1:0] HALF_TURN = 34'sd1179648000;
    localparam logic signed [Z_W-1:0] FULL_TURN = 34'sd2359296000;
    localparam logic signed [Z_W-1:0] ANG_HALF  = 34'sd32768;

    localparam logic [VAL_W-1:0] MIN_INTERVAL_RST = 16'd500;
    localparam logic [VAL_W-1:0] MIN_DISTANCE_RST = 16'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd1;

    // atan(2^-i) in 1/65536 of 0.01 degree
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        29'd294912000, 29'd174096719, 29'd91987925, 29'd46694507, 29'd23437865,
        29'd11730358,  29'd5866610,   29'd2933484,  29'd1466764,  29'd733385,
        29'd366693,    29'd183346,    29'd91673,    29'd45837,    29'd22918,
        29'd11459,     29'd5730,      29'd2865,     29'd1432,     29'd716
    };

    typedef enum logic [1:0] {
        OUT_FIRST,
        OUT_SHORT,
        OUT_STILL,
        OUT_MOVING
    } t_outcome;

    typedef enum logic {
        SD_SQRT,
        SD_DIV
    } t_sd_mode;

    typedef struct packed {
        logic     start;
        t_sd_mode mode;
    } t_sd_cmd;

    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [TIME_W-1:0]       t;
        logic [VAL_W-1:0]        speed;
        logic [VAL_W-1:0]        course;
    } t_slot_rec;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQ_MD,
        ST_CMP,
        ST_ROOT,
        ST_SCALE,
        ST_DIV,
        ST_FINISH
    } t_state;

endpackage

// ===== src/fix_pair_speed_heading.sv =====
// Top level: per-slot fix store, sequencer and result register for speed and course.
// Flow: a first fix or a short interval finishes right after the check; else the squared
// distance against the minimum distance finds standing still, and a moving fix runs 29
// root steps, then 16 divide steps unless speed saturates, in the shared subtract unit;
// CORDIC runs alongside. Throughput: one fix at a time; stalls while a result waits.
// Reset: after reset a clearing pass of TRACK_SLOTS cycles empties the slot store.
`timescale 1ns / 1ps

module fix_pair_speed_heading
    import fpsh_pkg::*;
#(
    parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [VAL_W-1:0]         i_cfg_data,
    input  logic                     i_fix_valid,
    output logic                     o_fix_ready,
    input  logic [SLOT_IN_W-1:0]     i_slot,
    input  logic                     i_new_track,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic [TIME_W-1:0]        i_fix_time,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output logic [VAL_W-1:0]         o_speed,
    output logic [VAL_W-1:0]         o_course,
    output logic [1:0]               o_outcome
);

    localparam int SLOT_W     = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int SLOT_CODES = 1 << SLOT_IN_W;

    // Sequencer and configuration
    t_state                  r_state;
    t_state                  n_state;
    logic [SLOT_W-1:0]       r_clr;
    logic [VAL_W-1:0]        r_min_interval;
    logic [VAL_W-1:0]        r_min_distance;

    // Captured fix and slot record
    logic [SLOT_W-1:0]       r_idx;
    logic                    r_new_track;
    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;
    logic [TIME_W-1:0]       r_t;
    t_slot_rec               r_rd;
    t_slot_rec               r_slot_mem [TRACK_SLOTS];

    // Working values
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [TIME_W-1:0]        r_dt;
    logic [D2_W-1:0]          r_d2;
    logic [VAL_W-1:0]         r_speed;
    logic [VAL_W-1:0]         r_course;
    t_outcome                 r_outcome;

    // Result register
    logic                     r_res_valid;
    logic [VAL_W-1:0]         r_out_speed;
    logic [VAL_W-1:0]         r_out_course;
    t_outcome                 r_out_outcome;

    logic [SLOT_W-1:0]        w_slot_map [SLOT_CODES];
    logic                     w_fix_accept;
    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic [TIME_W-1:0]        w_dt;
    logic                     w_first;
    logic                     w_short;
    logic                     w_still;
    logic                     w_sat;
    logic                     w_out_free;
    logic [VAL_W-1:0]         w_course_final;

    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    t_sd_cmd                  w_sd_cmd;
    logic                     w_sd_busy;
    logic [ROOT_W-1:0]        w_sd_result;
    logic                     w_cordic_start;
    logic                     w_cordic_busy;
    logic [VAL_W-1:0]         w_cordic_course;
    logic                     w_mem_we;
    logic [SLOT_W-1:0]        w_mem_addr;
    t_slot_rec                w_mem_wdata;
    logic                     w_res_load;

    // Fold the slot number into the store depth
    for (genvar k = 0; k < SLOT_CODES; k++) begin : g_slot_map
        localparam int SLOT_MOD = k % TRACK_SLOTS;
        assign w_slot_map[k] = SLOT_W'(SLOT_MOD);
    end

    assign w_fix_accept = i_fix_valid && o_fix_ready;
    assign o_fix_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign w_out_free   = !r_res_valid || i_res_ready;

    // Compare the fix with the stored one
    always_comb begin
        w_dx    = DIFF_W'(r_x) - DIFF_W'(r_rd.x);
        w_dy    = DIFF_W'(r_y) - DIFF_W'(r_rd.y);
        w_dt    = r_t - r_rd.t;
        w_first = !r_rd.valid || r_new_track;
        w_short = (w_dt == '0) || (w_dt < TIME_W'(r_min_interval));
        w_still = (r_d2 == '0) || (r_d2 < w_prod[D2_W-1:0]);
        w_sat   = (TIME_W'(w_prod[SCALED_W-1:DIV_STEPS]) >= r_dt);
        w_course_final = (r_outcome == OUT_MOVING) ? w_cordic_course : r_course;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == SLOT_W'(TRACK_SLOTS - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (w_fix_accept) n_state = ST_CHECK;
            ST_CHECK:  n_state = (w_first || w_short) ? ST_FINISH : ST_SQ_DX;
            ST_SQ_DX:  n_state = ST_SQ_DY;
            ST_SQ_DY:  n_state = ST_SQ_MD;
            ST_SQ_MD:  n_state = ST_CMP;
            ST_CMP:    n_state = w_still ? ST_FINISH : ST_ROOT;
            ST_ROOT:   if (!w_sd_busy) n_state = ST_SCALE;
            ST_SCALE:  n_state = w_sat ? ST_FINISH : ST_DIV;
            ST_DIV:    if (!w_sd_busy) n_state = ST_FINISH;
            ST_FINISH: if (!w_cordic_busy && w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, unit starts, store write
    always_comb begin
        w_mul_a        = '0;
        w_mul_b        = '0;
        w_sd_cmd       = '{start: 1'b0, mode: SD_SQRT};
        w_cordic_start = 1'b0;
        w_mem_we       = 1'b0;
        w_mem_addr     = r_idx;
        w_mem_wdata    = '{valid: 1'b1, x: r_x, y: r_y, t: r_t,
                           speed: r_speed, course: w_course_final};
        w_res_load     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr;
                w_mem_wdata = '0;
            end
            ST_SQ_DX: begin
                w_mul_a = MUL_W'(r_dx);
                w_mul_b = MUL_W'(r_dx);
            end
            ST_SQ_DY: begin
                w_mul_a = MUL_W'(r_dy);
                w_mul_b = MUL_W'(r_dy);
            end
            ST_SQ_MD: begin
                w_mul_a = MUL_W'(r_min_distance);
                w_mul_b = MUL_W'(r_min_distance);
            end
            ST_CMP: begin
                if (!w_still) begin
                    w_sd_cmd       = '{start: 1'b1, mode: SD_SQRT};
                    w_cordic_start = 1'b1;
                end
            end
            ST_ROOT: begin
                w_mul_a = MUL_W'(w_sd_result);
                w_mul_b = MUL_W'(SPEED_SCALE);
            end
            ST_SCALE: begin
                if (!w_sat) begin
                    w_sd_cmd = '{start: 1'b1, mode: SD_DIV};
                end
            end
            ST_FINISH: begin
                if (!w_cordic_busy && w_out_free) begin
                    w_mem_we   = 1'b1;
                    w_res_load = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // State, clearing counter and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr          <= '0;
            r_min_interval <= MIN_INTERVAL_RST;
            r_min_distance <= MIN_DISTANCE_RST;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                    CFG_MIN_DISTANCE: r_min_distance <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Slot store: one write port, registered read at fix accept
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_slot_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_fix_accept) begin
            r_rd <= r_slot_mem[w_slot_map[i_slot]];
        end
    end

    // Capture the fix and advance the working values
    always_ff @(posedge i_clk) begin
        if (w_fix_accept) begin
            r_idx       <= w_slot_map[i_slot];
            r_new_track <= i_new_track;
            r_x         <= i_pos_x;
            r_y         <= i_pos_y;
            r_t         <= i_fix_time;
        end
        case (r_state)
            ST_CHECK: begin
                r_dx <= w_dx;
                r_dy <= w_dy;
                r_dt <= w_dt;
                if (w_first) begin
                    r_outcome <= OUT_FIRST;
                    r_speed   <= '0;
                    r_course  <= '0;
                end else begin
                    r_outcome <= OUT_SHORT;
                    r_speed   <= r_rd.speed;
                    r_course  <= r_rd.course;
                end
            end
            ST_SQ_DY: r_d2 <= D2_W'(w_prod);
            ST_SQ_MD: r_d2 <= r_d2 + D2_W'(w_prod);
            ST_CMP: begin
                if (w_still) begin
                    r_outcome <= OUT_STILL;
                    r_speed   <= '0;
                end else begin
                    r_outcome <= OUT_MOVING;
                end
            end
            ST_SCALE: if (w_sat) r_speed <= SPEED_MAX;
            ST_DIV:   if (!w_sd_busy) r_speed <= w_sd_result[VAL_W-1:0];
            default: ;
        endcase
    end

    // Result register: hold a beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_res_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_speed   <= r_speed;
            r_out_course  <= w_course_final;
            r_out_outcome <= r_outcome;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_speed     = r_out_speed;
    assign o_course    = r_out_course;
    assign o_outcome   = r_out_outcome;

    fpsh_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    fpsh_sqdiv u_sqdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_sd_cmd),
        .i_operand (w_sd_cmd.mode == SD_SQRT ? {r_d2, 8'h00} : RAD_W'(w_prod[SCALED_W-1:0])),
        .i_divisor (r_dt),
        .o_busy    (w_sd_busy),
        .o_result  (w_sd_result)
    );

    fpsh_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cordic_start),
        .i_east   (r_dx),
        .i_north  (r_dy),
        .o_busy   (w_cordic_busy),
        .o_course (w_cordic_course)
    );

    // A result beat appears only out of the finishing step
    a_res_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(r_state == ST_FINISH))
        else $error("result beat raised outside finish step");

    // Standing still always reports zero speed
    a_still_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_outcome == OUT_STILL) |-> (o_speed == '0))
        else $error("standing still with nonzero speed");

    // A first fix reports cleared motion
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_outcome == OUT_FIRST) |-> (o_speed == '0 && o_course == '0))
        else $error("first fix with nonzero motion");

    // Course stays within one turn
    a_course_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_course < COURSE_WRAP))
        else $error("course out of range");

    // The shared subtract unit is never restarted mid-operation
    a_sd_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sd_cmd.start |-> !w_sd_busy)
        else $error("subtract unit started while busy");

endmodule

// ===== src/fpsh_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module fpsh_mul
    import fpsh_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // Register every product; the sequencer picks it up in the next state
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== src/fpsh_sqdiv.sv =====
// Shared restoring subtract unit: bit-pair square root and bit-serial divide.
`timescale 1ns / 1ps

module fpsh_sqdiv
    import fpsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sd_cmd           i_cmd,
    input  logic [RAD_W-1:0]  i_operand,
    input  logic [TIME_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_result
);

    logic              r_busy;
    t_sd_mode          r_mode;
    logic [STEP_W-1:0] r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [RAD_W-1:0]  r_src;
    logic [ROOT_W-1:0] r_q;

    logic [REM_W-1:0]  w_cand;
    logic [REM_W-1:0]  w_trial;
    logic [REM_W:0]    w_diff;
    logic              w_ge;

    // Form the partial remainder and the trial subtrahend for one step
    always_comb begin
        if (r_mode == SD_SQRT) begin
            w_cand  = {r_rem[REM_W-3:0], r_src[RAD_W-1 -: 2]};
            w_trial = {2'b00, r_q, 2'b01};
        end else begin
            w_cand  = {r_rem[REM_W-2:0], r_src[RAD_W-1]};
            w_trial = {1'b0, i_divisor};
        end
        w_diff = {1'b0, w_cand} - {1'b0, w_trial};
        w_ge   = !w_diff[REM_W];
    end

    // Step counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mode <= SD_SQRT;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_mode <= i_cmd.mode;
            r_cnt  <= (i_cmd.mode == SD_SQRT) ? STEP_W'(SQRT_STEPS - 1)
                                              : STEP_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Load operands, then shift in one digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q <= '0;
            if (i_cmd.mode == SD_SQRT) begin
                r_rem <= '0;
                r_src <= i_operand;
            end else begin
                r_rem <= REM_W'(i_operand[SCALED_W-1:DIV_STEPS]);
                r_src <= {i_operand[DIV_STEPS-1:0], (RAD_W - DIV_STEPS)'(0)};
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[REM_W-1:0] : w_cand;
            r_q   <= {r_q[ROOT_W-2:0], w_ge};
            r_src <= (r_mode == SD_SQRT) ? (r_src << 2) : (r_src << 1);
        end
    end

    assign o_busy   = r_busy;
    assign o_result = r_q;

endmodule

// ===== src/fpsh_cordic.sv =====
// Iterative vectoring CORDIC giving the bearing of a displacement in 0.01 degree.
`timescale 1ns / 1ps

module fpsh_cordic
    import fpsh_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_east,
    input  logic signed [DIFF_W-1:0] i_north,
    output logic                     o_busy,
    output logic [VAL_W-1:0]         o_course
);

    logic                    r_busy;
    logic                    r_round;
    logic [STEP_W-1:0]       r_step;
    logic signed [CX_W-1:0]  r_x;
    logic signed [CX_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [VAL_W-1:0]        r_course;

    logic signed [CX_W-1:0]  w_x0;
    logic signed [CX_W-1:0]  w_y0;
    logic signed [CX_W-1:0]  w_xs;
    logic signed [CX_W-1:0]  w_ys;
    logic signed [Z_W-1:0]   w_ang;
    logic signed [Z_W-1:0]   w_wrap;
    logic signed [Z_W-1:0]   w_half;
    logic [VAL_W-1:0]        w_deg;
    logic [VAL_W-1:0]        w_course;

    // Scale the vector and shift it for the current micro-rotation
    always_comb begin
        w_x0  = CX_W'(i_north) <<< ANG_FRAC;
        w_y0  = CX_W'(i_east) <<< ANG_FRAC;
        w_xs  = r_x >>> r_step;
        w_ys  = r_y >>> r_step;
        w_ang = signed'({{(Z_W - ATAN_W){1'b0}}, ATAN_TAB[r_step]});
    end

    // Wrap into one turn and round to the nearest 0.01 degree
    always_comb begin
        w_wrap   = (r_z < 0) ? (r_z + FULL_TURN) : r_z;
        w_half   = w_wrap + ANG_HALF;
        w_deg    = w_half[ANG_FRAC +: VAL_W];
        w_course = (w_deg >= COURSE_WRAP) ? (w_deg - COURSE_WRAP) : w_deg;
    end

    // Sequence the rotations and the final rounding cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_step  <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_round <= 1'b0;
            r_step  <= '0;
        end else if (r_round) begin
            r_round <= 1'b0;
            r_busy  <= 1'b0;
        end else if (r_busy) begin
            if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                r_round <= 1'b1;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Rotate toward the north axis, accumulating the angle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_north < 0) begin
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= HALF_TURN;
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end else if (r_busy && !r_round) begin
            if (r_y > 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_ang;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_ang;
            end
        end
        if (r_round) begin
            r_course <= w_course;
        end
    end

    assign o_busy   = r_busy;
    assign o_course = r_course;

endmodule
